@@ hw/rtl/ceu_pkg.sv @@
// Shared constants, types and helpers of the command execute unit.
`timescale 1ns / 1ps

package ceu_pkg;

  localparam int NUM_REGS    = 32;
  localparam int MEM_BYTES   = 4096;
  localparam int STACK_DEPTH = 16;

  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam int CNT_W       = $clog2(NUM_REGS + 1);
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int ROW_AW      = MEM_AW - 3;
  localparam int BANK_AW     = MEM_AW - 4;
  localparam int BANK_ROWS   = (MEM_BYTES + 15) / 16;
  localparam int FRAME_DEPTH = STACK_DEPTH * NUM_REGS;
  localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
  localparam int FB_W        = $clog2(FRAME_DEPTH + 1);
  localparam int FA_W        = FB_W + 1;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int LVL_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [4:0] FN_NOP    = 5'd0;
  localparam logic [4:0] FN_MOV    = 5'd1;
  localparam logic [4:0] FN_ADD    = 5'd2;
  localparam logic [4:0] FN_SUB    = 5'd3;
  localparam logic [4:0] FN_CMP    = 5'd4;
  localparam logic [4:0] FN_CMPU   = 5'd5;
  localparam logic [4:0] FN_PRINT  = 5'd6;
  localparam logic [4:0] FN_AND    = 5'd7;
  localparam logic [4:0] FN_ORR    = 5'd8;
  localparam logic [4:0] FN_EOR    = 5'd9;
  localparam logic [4:0] FN_ASR    = 5'd10;
  localparam logic [4:0] FN_LSR    = 5'd11;
  localparam logic [4:0] FN_LSL    = 5'd12;
  localparam logic [4:0] FN_STORE  = 5'd13;
  localparam logic [4:0] FN_LOAD   = 5'd14;
  localparam logic [4:0] FN_BRANCH = 5'd15;
  localparam logic [4:0] FN_CALL   = 5'd16;
  localparam logic [4:0] FN_RET    = 5'd17;

  localparam logic [2:0] COND_AL = 3'd0;
  localparam logic [2:0] COND_EQ = 3'd1;
  localparam logic [2:0] COND_NE = 3'd2;
  localparam logic [2:0] COND_GT = 3'd3;
  localparam logic [2:0] COND_LT = 3'd4;
  localparam logic [2:0] COND_GE = 3'd5;
  localparam logic [2:0] COND_LE = 3'd6;

  localparam logic [2:0] FMT_BIN = 3'd2;  // highest valid print base

  localparam logic [1:0] KIND_FALL = 2'd0;
  localparam logic [1:0] KIND_JUMP = 2'd1;
  localparam logic [1:0] KIND_HALT = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD,
    ST_CALL,
    ST_RET
  } state_t;

  typedef struct packed {
    logic              re;
    logic [REG_AW-1:0] ra_addr;
    logic [REG_AW-1:0] rb_addr;
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [63:0]       wdata;
  } rf_req_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [BANK_AW-1:0] even_idx;
    logic [BANK_AW-1:0] odd_idx;
    logic [7:0]         even_be;
    logic [7:0]         odd_be;
    logic [63:0]        even_wd;
    logic [63:0]        odd_wd;
  } dmem_req_t;

  typedef struct packed {
    logic                we;
    logic [FRAME_AW-1:0] waddr;
    logic [63:0]         wdata;
    logic                re;
    logic [FRAME_AW-1:0] raddr;
  } frame_req_t;

  function automatic logic [REG_AW-1:0] reg_idx(input logic [4:0] i);
    logic [5:0] e;
    e = {1'b0, i};
    return e[REG_AW-1:0];
  endfunction

  function automatic logic reg_ok(input logic [4:0] i);
    return {2'b00, i} < 7'(NUM_REGS);
  endfunction

endpackage

@@ hw/rtl/command_execute_unit_top.sv @@
// Command execute unit: sequencer and datapath around register file, data memory and frames.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  func .. target_found, one command word
//  out      output     out_valid/out_stall  next_pc .. error, one result word
//
// One command at a time: an accept state and an execute state for most commands; load adds
// a data memory read state, and call and return add a copy between register file and frame
// store, one register per cycle.
// After reset the data memory is swept to zero row by row, in_stall high.
// A result waits in the output register; a new command is taken meanwhile, and its own
// result holds in the last execute state until the output register frees.
`timescale 1ns / 1ps

module command_execute_unit_top import ceu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         func,
  input  logic [4:0]         dest,
  input  logic [4:0]         src_a,
  input  logic [4:0]         src_b,
  input  logic               a_is_imm,
  input  logic               b_is_imm,
  input  logic signed [63:0] imm_a,
  input  logic signed [63:0] imm_b,
  input  logic [2:0]         variant,
  input  logic [15:0]        pc,
  input  logic [15:0]        target_pc,
  input  logic               target_found,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        next_pc,
  output logic [1:0]         next_kind,
  output logic               print_valid,
  output logic signed [63:0] print_value,
  output logic [1:0]         print_format,
  output logic               out_greater,
  output logic               out_less,
  output logic               out_equal,
  output logic               error
);

  state_t state, state_next;

  // latched command word
  logic [4:0]  func_q, dest_q;
  logic        a_imm_q, b_imm_q, found_q, a_ok_q, b_ok_q;
  logic [63:0] ia_q, ib_q;
  logic [2:0]  var_q;
  logic [15:0] pc_q, tpc_q;

  logic               gt, lt, eq, err_sticky;
  logic [LVL_W-1:0]   level;
  logic [FB_W-1:0]    fbase;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [15:0]        ret_store [STACK_DEPTH];
  logic [15:0]        ret_pc_q;
  logic               ld_par;
  logic [2:0]         ld_off;
  logic [3:0]         ld_n;

  rf_req_t    rf_req;
  dmem_req_t  dm_req;
  frame_req_t fr_req;
  logic [63:0] rf_a, rf_b, dm_even, dm_odd, fr_rdata;
  logic        dm_busy;

  logic accept, out_free;

  ceu_regfile u_rf (.clk(clk), .rst(rst), .req(rf_req), .rd_a(rf_a), .rd_b(rf_b));
  ceu_dmem u_dm (
    .clk(clk), .rst(rst), .req(dm_req), .busy(dm_busy), .rd_even(dm_even), .rd_odd(dm_odd)
  );
  ceu_frames u_fr (.clk(clk), .req(fr_req), .rdata(fr_rdata));

  assign in_stall = (state != ST_IDLE) || dm_busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  function automatic logic [7:0] byte_mask(input logic [3:0] n);
    logic [8:0] t;
    t = (9'd1 << n) - 9'd1;
    return t[7:0];
  endfunction

  function automatic logic [63:0] bits_of(input logic [7:0] m);
    logic [63:0] r;
    for (int b = 0; b < 8; b++) begin
      r[8*b +: 8] = {8{m[b]}};
    end
    return r;
  endfunction

  // ---------------- execute decode ----------------
  logic [63:0] ra, rbv, opa, opb;
  logic [15:0] pc1;
  logic        mem_ok, dest_ok, take, full;
  logic [ROW_AW-1:0]  ex_row;
  logic [2:0]         ex_off;
  logic [127:0]       st_win;
  logic [15:0]        st_mask;
  logic [BANK_AW-1:0] ev_idx, od_idx;

  logic        ex_err, ex_wr, ex_flags, ex_gt, ex_lt, ex_eq, ex_pv, ex_st, ex_ld;
  logic        ex_call, ex_ret;
  logic [63:0] ex_wd, ex_pval;
  logic [1:0]  ex_pfmt, ex_kind;
  logic [15:0] ex_pc;

  always_comb begin
    ra      = a_ok_q ? rf_a : '0;
    rbv     = b_ok_q ? rf_b : '0;
    opa     = a_imm_q ? ia_q : ra;
    opb     = b_imm_q ? ib_q : rbv;
    pc1     = pc_q + 16'd1;
    dest_ok = reg_ok(dest_q);
    full    = (level == LVL_W'(STACK_DEPTH));
    mem_ok  = (ib_q != 64'd0) && (ib_q <= 64'd8) && (opa < 64'(MEM_BYTES)) &&
              (ib_q <= 64'(MEM_BYTES) - opa);
    ex_row  = opa[MEM_AW-1:3];
    ex_off  = opa[2:0];
    st_win  = {64'b0, rbv} << {ex_off, 3'b000};
    st_mask = {8'b0, byte_mask(ib_q[3:0])} << ex_off;
    od_idx  = ex_row[ROW_AW-1:1];
    ev_idx  = ex_row[0] ? BANK_AW'(ex_row[ROW_AW-1:1] + 1'b1) : ex_row[ROW_AW-1:1];

    ex_err = 1'b0; ex_wr = 1'b0; ex_wd = '0; ex_flags = 1'b0;
    ex_gt = 1'b0; ex_lt = 1'b0; ex_eq = 1'b0;
    ex_pv = 1'b0; ex_pval = '0; ex_pfmt = 2'd0;
    ex_st = 1'b0; ex_ld = 1'b0; ex_call = 1'b0; ex_ret = 1'b0;
    ex_pc = pc1; ex_kind = KIND_FALL; take = 1'b0;

    if (err_sticky) begin
      ex_err = 1'b1;
    end else begin
      case (func_q)
        FN_NOP: ;
        FN_MOV: begin
          if (!a_imm_q) ex_err = 1'b1;
          else begin ex_wr = 1'b1; ex_wd = ia_q; end
        end
        FN_ADD: begin ex_wr = 1'b1; ex_wd = ra + opb; end
        FN_SUB: begin ex_wr = 1'b1; ex_wd = ra - opb; end
        FN_CMP: begin
          ex_flags = 1'b1;
          ex_gt = $signed(ra) > $signed(opb);
          ex_lt = $signed(ra) < $signed(opb);
          ex_eq = ra == opb;
        end
        FN_CMPU: begin
          ex_flags = 1'b1;
          ex_gt = ra > opb;
          ex_lt = ra < opb;
          ex_eq = ra == opb;
        end
        FN_PRINT: begin
          if (var_q > FMT_BIN) ex_err = 1'b1;
          else begin ex_pv = 1'b1; ex_pval = opa; ex_pfmt = var_q[1:0]; end
        end
        FN_AND: begin ex_wr = 1'b1; ex_wd = ra & rbv; end
        FN_ORR: begin ex_wr = 1'b1; ex_wd = ra | rbv; end
        FN_EOR: begin ex_wr = 1'b1; ex_wd = ra ^ rbv; end
        FN_ASR: begin ex_wr = 1'b1; ex_wd = $signed(ra) >>> ib_q[5:0]; end
        FN_LSR: begin ex_wr = 1'b1; ex_wd = ra >> ib_q[5:0]; end
        FN_LSL: begin ex_wr = 1'b1; ex_wd = ra << ib_q[5:0]; end
        FN_STORE: begin
          if (!mem_ok) ex_err = 1'b1;
          else ex_st = 1'b1;
        end
        FN_LOAD: begin
          if (!mem_ok) ex_err = 1'b1;
          else ex_ld = 1'b1;
        end
        FN_BRANCH: begin
          case (var_q)
            COND_AL: take = 1'b1;
            COND_EQ: take = eq;
            COND_NE: take = !eq;
            COND_GT: take = gt;
            COND_LT: take = lt;
            COND_GE: take = gt || eq;
            COND_LE: take = lt || eq;
            default: ex_err = 1'b1;
          endcase
          if (take && !ex_err) begin
            if (!found_q) ex_err = 1'b1;
            else begin ex_pc = tpc_q; ex_kind = KIND_JUMP; end
          end
        end
        FN_CALL: begin
          if (full || !found_q) ex_err = 1'b1;
          else ex_call = 1'b1;
        end
        FN_RET: begin
          if (level == '0) begin ex_pc = pc_q; ex_kind = KIND_HALT; end
          else ex_ret = 1'b1;
        end
        default: begin ex_pc = pc_q; ex_kind = KIND_HALT; end
      endcase
    end

    if (ex_err) begin
      ex_pc = pc_q; ex_kind = KIND_ERR;
      ex_pv = 1'b0; ex_pval = '0; ex_pfmt = 2'd0;
    end
  end

  // ---------------- control outputs ----------------
  logic        fin, go_call, go_ret, go_load, push;
  logic        gt_next, lt_next, eq_next, err_next;
  logic [15:0] res_pc;
  logic [1:0]  res_kind;
  logic [FA_W-1:0]  fa;
  logic [CNT_W-1:0] cnt_m1;
  logic [127:0]     ld_win;
  logic [63:0]      ld_val;

  always_comb begin
    rf_req = '0; dm_req = '0; fr_req = '0;
    fin = 1'b0; go_call = 1'b0; go_ret = 1'b0; go_load = 1'b0; push = 1'b0;
    gt_next = gt; lt_next = lt; eq_next = eq; err_next = err_sticky;
    res_pc = pc1; res_kind = KIND_FALL;
    cnt_next = cnt;
    cnt_m1 = cnt - CNT_W'(1);
    fa = '0;
    ld_win = (ld_par ? {dm_even, dm_odd} : {dm_odd, dm_even}) >> {ld_off, 3'b000};
    ld_val = ld_win[63:0] & bits_of(byte_mask(ld_n));

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          rf_req.re      = 1'b1;
          rf_req.ra_addr = reg_idx(src_a);
          rf_req.rb_addr = reg_idx((func == FN_STORE) ? dest : src_b);
        end
      end
      ST_EXEC: begin
        res_pc = ex_pc; res_kind = ex_kind;
        if (ex_call) begin
          go_call = 1'b1; cnt_next = '0;
        end else if (ex_ret) begin
          go_ret = 1'b1; cnt_next = CNT_W'(1);
        end else if (ex_ld) begin
          go_load = 1'b1;
          dm_req.re = 1'b1; dm_req.even_idx = ev_idx; dm_req.odd_idx = od_idx;
        end else if (out_free) begin
          fin = 1'b1;
          if (ex_err) err_next = 1'b1;
          if (ex_flags) begin gt_next = ex_gt; lt_next = ex_lt; eq_next = ex_eq; end
          rf_req.we = ex_wr && dest_ok;
          rf_req.waddr = reg_idx(dest_q);
          rf_req.wdata = ex_wd;
          dm_req.we = ex_st;
          dm_req.even_idx = ev_idx;
          dm_req.odd_idx  = od_idx;
          dm_req.even_be  = ex_row[0] ? st_mask[15:8] : st_mask[7:0];
          dm_req.odd_be   = ex_row[0] ? st_mask[7:0] : st_mask[15:8];
          dm_req.even_wd  = ex_row[0] ? st_win[127:64] : st_win[63:0];
          dm_req.odd_wd   = ex_row[0] ? st_win[63:0] : st_win[127:64];
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          fin = 1'b1;
          rf_req.we = dest_ok;
          rf_req.waddr = reg_idx(dest_q);
          rf_req.wdata = ld_val;
        end
      end
      ST_CALL: begin
        // read register cnt, write the register read in the previous cycle to the frame
        res_pc = tpc_q; res_kind = KIND_JUMP;
        if (cnt < CNT_W'(NUM_REGS)) begin
          rf_req.re = 1'b1;
          rf_req.ra_addr = cnt[REG_AW-1:0];
          cnt_next = cnt + CNT_W'(1);
        end
        if (cnt != '0) begin
          fa = FA_W'(fbase) + FA_W'(cnt) - FA_W'(1);
          fr_req.we = 1'b1;
          fr_req.waddr = fa[FRAME_AW-1:0];
          fr_req.wdata = rf_a;
        end
        if (cnt == CNT_W'(NUM_REGS) && out_free) begin
          fin = 1'b1; push = 1'b1;
        end
      end
      ST_RET: begin
        // register 0 is not restored
        res_pc = ret_pc_q; res_kind = KIND_JUMP;
        if (cnt < CNT_W'(NUM_REGS)) begin
          fa = FA_W'(fbase) + FA_W'(cnt);
          fr_req.re = 1'b1;
          fr_req.raddr = fa[FRAME_AW-1:0];
          cnt_next = cnt + CNT_W'(1);
        end
        if (cnt > CNT_W'(1)) begin
          rf_req.we = 1'b1;
          rf_req.waddr = cnt_m1[REG_AW-1:0];
          rf_req.wdata = fr_rdata;
        end
        if (cnt == CNT_W'(NUM_REGS) && out_free) begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: begin
        if (go_call)      state_next = ST_CALL;
        else if (go_ret)  state_next = ST_RET;
        else if (go_load) state_next = ST_LOAD;
        else if (fin)     state_next = ST_IDLE;
      end
      ST_LOAD, ST_CALL, ST_RET: if (fin) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- registers ----------------
  logic [LVL_W-1:0] lvl_m1;
  assign lvl_m1 = level - LVL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      gt         <= 1'b0;
      lt         <= 1'b0;
      eq         <= 1'b0;
      err_sticky <= 1'b0;
      level      <= '0;
      fbase      <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      gt         <= gt_next;
      lt         <= lt_next;
      eq         <= eq_next;
      err_sticky <= err_next;
      cnt        <= cnt_next;
      if (push) begin
        level <= level + LVL_W'(1);
        fbase <= fbase + FB_W'(NUM_REGS);
      end else if (go_ret) begin
        level <= lvl_m1;
        fbase <= fbase - FB_W'(NUM_REGS);
      end
      if (fin)             out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q  <= func;
      dest_q  <= dest;
      a_imm_q <= a_is_imm;
      b_imm_q <= b_is_imm;
      ia_q    <= imm_a;
      ib_q    <= imm_b;
      var_q   <= variant;
      pc_q    <= pc;
      tpc_q   <= target_pc;
      found_q <= target_found;
      a_ok_q  <= reg_ok(src_a);
      b_ok_q  <= reg_ok((func == FN_STORE) ? dest : src_b);
    end
    if (go_load) begin
      ld_par <= ex_row[0];
      ld_off <= ex_off;
      ld_n   <= ib_q[3:0];
    end
    if (go_ret) begin
      ret_pc_q <= ret_store[lvl_m1[LVL_AW-1:0]];
    end
    if (push) begin
      ret_store[level[LVL_AW-1:0]] <= pc1;
    end
    if (fin) begin
      next_pc      <= res_pc;
      next_kind    <= res_kind;
      print_valid  <= (state == ST_EXEC) && ex_pv;
      print_value  <= (state == ST_EXEC) ? ex_pval : '0;
      print_format <= (state == ST_EXEC) ? ex_pfmt : 2'd0;
      out_greater  <= gt_next;
      out_less     <= lt_next;
      out_equal    <= eq_next;
      error        <= err_next;
    end
  end

endmodule

@@ hw/rtl/ceu_regfile.sv @@
// Register file: two registered read ports, one write port, per-entry valid bits.
`timescale 1ns / 1ps

module ceu_regfile import ceu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rf_req_t     req,
  output logic [63:0] rd_a,
  output logic [63:0] rd_b
);

  logic [63:0]         regs [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  logic [63:0]         a_q;
  logic [63:0]         b_q;
  logic                a_v;
  logic                b_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      regs[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      a_q <= regs[req.ra_addr];
      b_q <= regs[req.rb_addr];
      a_v <= valid[req.ra_addr];
      b_v <= valid[req.rb_addr];
    end
  end

  // never-written entries read as zero
  assign rd_a = a_v ? a_q : '0;
  assign rd_b = b_v ? b_q : '0;

endmodule

@@ hw/rtl/ceu_dmem.sv @@
// Data memory: two banks of 8-byte rows with byte enables and a clear sweep after reset.
`timescale 1ns / 1ps

module ceu_dmem import ceu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dmem_req_t   req,
  output logic        busy,
  output logic [63:0] rd_even,
  output logic [63:0] rd_odd
);

  logic [63:0]        bank_even [BANK_ROWS];
  logic [63:0]        bank_odd  [BANK_ROWS];
  logic [BANK_AW-1:0] clr_idx;
  logic               clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == BANK_AW'(BANK_ROWS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      bank_even[clr_idx] <= '0;
      bank_odd[clr_idx]  <= '0;
    end else if (req.we) begin
      for (int b = 0; b < 8; b++) begin
        if (req.even_be[b]) begin
          bank_even[req.even_idx][8*b +: 8] <= req.even_wd[8*b +: 8];
        end
        if (req.odd_be[b]) begin
          bank_odd[req.odd_idx][8*b +: 8] <= req.odd_wd[8*b +: 8];
        end
      end
    end
  end

  // the upper row of an access may lie past the end; its bytes are masked off
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_even <= (req.even_idx < BANK_ROWS) ? bank_even[req.even_idx] : '0;
      rd_odd  <= (req.odd_idx < BANK_ROWS) ? bank_odd[req.odd_idx] : '0;
    end
  end

  assign busy = clearing;

endmodule

@@ hw/rtl/ceu_frames.sv @@
// Call frame store: saved register images, one write and one registered read port.
`timescale 1ns / 1ps

module ceu_frames import ceu_pkg::*; (
  input  logic        clk,
  input  frame_req_t  req,
  output logic [63:0] rdata
);

  logic [63:0] mem [FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ bench/ceu_checker.sv @@
// Checker for the command execute unit: watches both channels, predicts and compares results.
`timescale 1ns / 1ps

module ceu_checker import ceu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  func,
  input  logic [4:0]  dest,
  input  logic [4:0]  src_a,
  input  logic [4:0]  src_b,
  input  logic        a_is_imm,
  input  logic        b_is_imm,
  input  logic [63:0] imm_a,
  input  logic [63:0] imm_b,
  input  logic [2:0]  variant,
  input  logic [15:0] pc,
  input  logic [15:0] target_pc,
  input  logic        target_found,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] next_pc,
  input  logic [1:0]  next_kind,
  input  logic        print_valid,
  input  logic [63:0] print_value,
  input  logic [1:0]  print_format,
  input  logic        out_greater,
  input  logic        out_less,
  input  logic        out_equal,
  input  logic        error,
  output int          fail_cnt,
  output int          pending,
  output int          n_results
);

  typedef struct {
    logic [15:0] npc;
    logic [1:0]  kind;
    logic        pv;
    logic [63:0] pval;
    logic [1:0]  pfmt;
    logic        g, l, e, err;
  } outcome_t;

  logic [63:0] regs [NUM_REGS];
  logic [63:0] frames [STACK_DEPTH][NUM_REGS];
  logic [15:0] ret_pcs [STACK_DEPTH];
  logic [7:0]  mem [MEM_BYTES];
  logic        gt_f, lt_f, eq_f, err_st;
  int          lvl;
  outcome_t    expected_q [$];

  function automatic logic mem_ok(input logic [63:0] a, input logic [63:0] n);
    return n >= 1 && n <= 8 && a < 64'(MEM_BYTES) && n <= 64'(MEM_BYTES) - a;
  endfunction

  task automatic execute_cmd(output outcome_t o);
    logic [63:0] ra, opb, opa, v;
    logic [5:0]  sh;
    logic        bad, take;
    ra   = regs[src_a];
    opb  = b_is_imm ? imm_b : regs[src_b];
    opa  = a_is_imm ? imm_a : ra;
    sh   = imm_b[5:0];
    bad  = 1'b0;
    take = 1'b0;
    o.npc = pc + 16'd1;
    o.kind = KIND_FALL;
    o.pv = 1'b0;
    o.pval = '0;
    o.pfmt = '0;
    if (err_st) begin
      bad = 1'b1;
    end else begin
      case (func)
        FN_NOP: ;
        FN_MOV: if (!a_is_imm) bad = 1'b1; else regs[dest] = imm_a;
        FN_ADD: regs[dest] = ra + opb;
        FN_SUB: regs[dest] = ra - opb;
        FN_CMP: begin
          gt_f = $signed(ra) > $signed(opb);
          lt_f = $signed(ra) < $signed(opb);
          eq_f = ra == opb;
        end
        FN_CMPU: begin
          gt_f = ra > opb;
          lt_f = ra < opb;
          eq_f = ra == opb;
        end
        FN_PRINT: begin
          if (variant > FMT_BIN) bad = 1'b1;
          else begin
            o.pv = 1'b1;
            o.pval = opa;
            o.pfmt = variant[1:0];
          end
        end
        FN_AND: regs[dest] = ra & regs[src_b];
        FN_ORR: regs[dest] = ra | regs[src_b];
        FN_EOR: regs[dest] = ra ^ regs[src_b];
        FN_ASR: regs[dest] = $signed(ra) >>> sh;
        FN_LSR: regs[dest] = ra >> sh;
        FN_LSL: regs[dest] = ra << sh;
        FN_STORE: begin
          v = regs[dest];
          if (!mem_ok(opa, imm_b)) bad = 1'b1;
          else for (int k = 0; k < int'(imm_b); k++)
            mem[opa[MEM_AW-1:0] + MEM_AW'(k)] = v[8*k +: 8];
        end
        FN_LOAD: begin
          v = '0;
          if (!mem_ok(opa, imm_b)) bad = 1'b1;
          else begin
            for (int k = 0; k < int'(imm_b); k++)
              v[8*k +: 8] = mem[opa[MEM_AW-1:0] + MEM_AW'(k)];
            regs[dest] = v;
          end
        end
        FN_BRANCH: begin
          case (variant)
            COND_AL: take = 1'b1;
            COND_EQ: take = eq_f;
            COND_NE: take = !eq_f;
            COND_GT: take = gt_f;
            COND_LT: take = lt_f;
            COND_GE: take = gt_f || eq_f;
            COND_LE: take = lt_f || eq_f;
            default: bad = 1'b1;
          endcase
          if (take && !bad) begin
            if (!target_found) bad = 1'b1;
            else begin
              o.npc = target_pc;
              o.kind = KIND_JUMP;
            end
          end
        end
        FN_CALL: begin
          if (lvl >= STACK_DEPTH || !target_found) bad = 1'b1;
          else begin
            for (int i = 0; i < NUM_REGS; i++) frames[lvl][i] = regs[i];
            ret_pcs[lvl] = o.npc;
            lvl++;
            o.npc = target_pc;
            o.kind = KIND_JUMP;
          end
        end
        FN_RET: begin
          if (lvl == 0) begin
            o.npc = pc;
            o.kind = KIND_HALT;
          end else begin
            lvl--;
            // register 0 carries the return value, so it survives the return
            for (int i = 1; i < NUM_REGS; i++) regs[i] = frames[lvl][i];
            o.npc = ret_pcs[lvl];
            o.kind = KIND_JUMP;
          end
        end
        default: begin
          o.npc = pc;
          o.kind = KIND_HALT;
        end
      endcase
    end
    if (bad) begin
      err_st = 1'b1;
      o.npc = pc;
      o.kind = KIND_ERR;
      o.pv = 1'b0;
      o.pval = '0;
      o.pfmt = '0;
    end
    o.g = gt_f;
    o.l = lt_f;
    o.e = eq_f;
    o.err = err_st;
  endtask

  task automatic check_field(input string nm, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", nm, e, a);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t o;
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
      gt_f = 1'b0;
      lt_f = 1'b0;
      eq_f = 1'b0;
      err_st = 1'b0;
      lvl = 0;
      expected_q.delete();
      fail_cnt = 0;
      n_results = 0;
    end else begin
      if (in_valid && !in_stall) begin
        execute_cmd(o);
        expected_q.push_back(o);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          o = expected_q.pop_front();
          check_field("next_pc", 64'(o.npc), 64'(next_pc));
          check_field("next_kind", 64'(o.kind), 64'(next_kind));
          check_field("print_valid", 64'(o.pv), 64'(print_valid));
          check_field("print_value", o.pval, print_value);
          check_field("print_format", 64'(o.pfmt), 64'(print_format));
          check_field("out_greater", 64'(o.g), 64'(out_greater));
          check_field("out_less", 64'(o.l), 64'(out_less));
          check_field("out_equal", 64'(o.e), 64'(out_equal));
          check_field("error", 64'(o.err), 64'(error));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the command execute unit: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import ceu_pkg::*;

  typedef struct packed {
    logic [4:0]  fn, dst, sa, sb;
    logic        ai, bi;
    logic [63:0] ia, ib;
    logic [2:0]  vr;
    logic [15:0] pcv, tpc;
    logic        fnd;
  } cmd_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [4:0]         func = '0, dest = '0, src_a = '0, src_b = '0;
  logic               a_is_imm = 1'b0, b_is_imm = 1'b0;
  logic signed [63:0] imm_a = '0, imm_b = '0;
  logic [2:0]         variant = '0;
  logic [15:0]        pc = '0, target_pc = '0;
  logic               target_found = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        next_pc;
  logic [1:0]         next_kind;
  logic               print_valid;
  logic signed [63:0] print_value;
  logic [1:0]         print_format;
  logic               out_greater, out_less, out_equal, error;
  int                 fail_cnt, pending, n_results;

  int  n_sent = 0;
  int  depth = 0;
  int  idle_cnt = 0;
  int  err_kind;
  bit  calm = 1'b0;

  always #2 clk = ~clk;

  command_execute_unit_top u_dut (.*);
  ceu_checker u_chk (.*);

  always @(negedge clk) out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 38);

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= 4000) begin
      $display("timeout: no word moved for %0d cycles", idle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    case ($urandom_range(0, 5))
      0: return 64'h7fff_ffff_ffff_ffff;
      1: return 64'h8000_0000_0000_0000;
      2: return '1;
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cmd_t mk(logic [4:0] fn, logic [4:0] dst, logic [4:0] sa, logic [4:0] sb,
                              logic ai, logic bi, logic [63:0] ia, logic [63:0] ib,
                              logic [2:0] vr);
    cmd_t c;
    c.fn = fn; c.dst = dst; c.sa = sa; c.sb = sb; c.ai = ai; c.bi = bi;
    c.ia = ia; c.ib = ib; c.vr = vr;
    c.pcv = 16'($urandom); c.tpc = 16'($urandom); c.fnd = 1'b1;
    return c;
  endfunction

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic send(input cmd_t c);
    if (!calm)
      while ($urandom_range(0, 99) < 38) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    func <= c.fn; dest <= c.dst; src_a <= c.sa; src_b <= c.sb;
    a_is_imm <= c.ai; b_is_imm <= c.bi; imm_a <= c.ia; imm_b <= c.ib;
    variant <= c.vr; pc <= c.pcv; target_pc <= c.tpc; target_found <= c.fnd;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (c.fn == FN_CALL && c.fnd && depth < STACK_DEPTH) depth++;
    if (c.fn == FN_RET && depth > 0) depth--;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic send_random();
    cmd_t c;
    logic [63:0] n, addr;
    c = mk(5'($urandom_range(0, 31)), 5'($urandom), 5'($urandom), 5'($urandom),
           1'($urandom), 1'($urandom), rnd64(), rnd64(), 3'($urandom));
    c.fnd = 1'($urandom);
    case ($urandom_range(0, 99)) inside
      [0:11]:  begin c.fn = FN_MOV; c.ai = 1'b1; end
      [12:39]: c.fn = 5'($urandom_range(FN_ADD, FN_CMPU));
      [40:45]: begin c.fn = FN_PRINT; c.vr = 3'($urandom_range(0, 2)); end
      [46:59]: c.fn = 5'($urandom_range(FN_AND, FN_LSL));
      [60:77]: begin
        c.fn = $urandom_range(0, 1) ? FN_STORE : FN_LOAD;
        n = 64'($urandom_range(1, 8));
        addr = $urandom_range(0, 3) == 0 ? 64'($urandom_range(0, 32'(64'(MEM_BYTES) - n)))
                                         : 64'($urandom_range(0, 40));
        if ($urandom_range(0, 3) == 0) addr = 64'(MEM_BYTES) - n;
        c.ib = n;
        c.ai = 1'($urandom);
        c.ia = addr;
        if (!c.ai) begin
          // base address goes through a register first
          send(mk(FN_MOV, c.sa, 0, 0, 1, 0, addr, 0, 0));
        end
      end
      [78:85]: begin c.fn = FN_BRANCH; c.vr = 3'($urandom_range(0, 6)); c.fnd = 1'b1; end
      [86:91]: begin
        c.fn = depth < STACK_DEPTH ? FN_CALL : FN_RET;
        c.fnd = 1'b1;
      end
      [92:97]: c.fn = FN_RET;
      default: c.fn = $urandom_range(0, 1) ? FN_NOP : 5'($urandom_range(18, 31));
    endcase
    send(c);
  endtask

  initial begin
    cmd_t c;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every operation, halts and wraparound
    send(mk(FN_RET, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FN_MOV, 1, 0, 0, 1, 0, 64'h7fff_ffff_ffff_ffff, 0, 0));
    send(mk(FN_MOV, 2, 0, 0, 1, 0, 64'h8000_0000_0000_0000, 0, 0));
    send(mk(FN_MOV, 3, 0, 0, 1, 1, '1, '1, 0));
    send(mk(FN_ADD, 4, 1, 2, 0, 0, 0, 0, 0));
    send(mk(FN_SUB, 5, 2, 0, 0, 1, 0, 1, 0));
    send(mk(FN_CMP, 0, 1, 2, 0, 0, 0, 0, 0));
    send(mk(FN_CMPU, 0, 1, 2, 0, 0, 0, 0, 0));
    send(mk(FN_BRANCH, 0, 0, 0, 0, 0, 0, 0, COND_GT));
    send(mk(FN_CMP, 0, 3, 0, 0, 1, 0, '1, 0));
    send(mk(FN_BRANCH, 0, 0, 0, 0, 0, 0, 0, COND_NE));
    send(mk(FN_PRINT, 0, 2, 0, 0, 0, 0, 0, 0));
    send(mk(FN_PRINT, 0, 0, 0, 1, 0, 64'h8000_0000_0000_0000, 0, 1));
    send(mk(FN_PRINT, 0, 0, 0, 1, 0, '1, 0, 2));
    send(mk(FN_AND, 6, 1, 3, 0, 1, 0, 0, 0));
    send(mk(FN_ORR, 7, 1, 2, 0, 0, 0, 0, 0));
    send(mk(FN_EOR, 8, 3, 1, 0, 0, 0, 0, 0));
    send(mk(FN_ASR, 9, 2, 0, 0, 0, 0, 64'hffff_ffff_ffff_ffff, 0));
    send(mk(FN_LSR, 10, 2, 0, 0, 0, 0, 64'h40, 0));
    send(mk(FN_LSL, 11, 3, 0, 0, 0, 0, 63, 0));
    send(mk(FN_STORE, 2, 0, 0, 1, 1, MEM_BYTES - 8, 8, 0));
    send(mk(FN_LOAD, 12, 0, 0, 1, 1, MEM_BYTES - 8, 8, 0));
    send(mk(FN_LOAD, 13, 0, 0, 1, 1, MEM_BYTES - 1, 1, 0));
    send(mk(FN_CALL, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FN_MOV, 1, 0, 0, 1, 0, 0, 0, 0));
    send(mk(FN_RET, 0, 0, 0, 0, 0, 0, 0, 0));
    c = mk(5'd31, 0, 0, 0, 0, 0, 0, 0, 0);
    send(c);
    c = mk(FN_NOP, 0, 0, 0, 0, 0, 0, 0, 0);
    c.pcv = 16'hffff;
    c.fnd = 1'b0;
    send(c);

    for (int i = 0; i < 440; i++) begin
      calm = (i >= 200 && i < 300);
      if (i == 400) drain();
      send_random();
    end

    // one sticky error per run, then commands that must all stop with it
    drain();
    err_kind = $urandom_range(0, 6);
    case (err_kind)
      0: send(mk(FN_MOV, 1, 2, 0, 0, 0, 0, 0, 0));
      1: send(mk(FN_PRINT, 0, 0, 0, 1, 0, 5, 0, 3));
      2: send(mk(FN_BRANCH, 0, 0, 0, 0, 0, 0, 0, 7));
      3: begin c = mk(FN_CALL, 0, 0, 0, 0, 0, 0, 0, 0); c.fnd = 1'b0; send(c); end
      4: send(mk(FN_STORE, 1, 0, 0, 1, 1, MEM_BYTES - 2, 64'($urandom_range(3, 9)), 0));
      5: begin c = mk(FN_BRANCH, 0, 0, 0, 0, 0, 0, 0, COND_AL); c.fnd = 1'b0; send(c); end
      default: begin
        while (depth < STACK_DEPTH) send(mk(FN_CALL, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(FN_CALL, 0, 0, 0, 0, 0, 0, 0, 0));
      end
    endcase
    repeat (6) send_random();

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("ran %0d commands, %0d results checked; directed edges, random mix with calls,",
             n_sent, n_results);
    $display("memory round trips, a drain pause and closing error case %0d", err_kind);
    if (fail_cnt == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ceu_pkg.sv
hw/rtl/ceu_regfile.sv
hw/rtl/ceu_dmem.sv
hw/rtl/ceu_frames.sv
hw/rtl/command_execute_unit_top.sv
bench/ceu_checker.sv
bench/tb.sv
